FILE: hw/rtl/palt_pkg.sv
`timescale 1ns / 1ps

package palt_pkg;

    // command codes of one input beat
    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_APPEND  = 2'd1,
        KIND_NEAREST = 2'd2,
        KIND_INTERP  = 2'd3
    } palt_kind_t;

    localparam logic [39:0] ARC_MAX    = 40'hFF_FFFF_FFFF;
    localparam int          SQRT_STEPS = 34;
    localparam int          DIV_STEPS  = 64;

    typedef struct packed {
        palt_kind_t         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic [39:0]        arc_query;
    } palt_in_t;

    typedef struct packed {
        logic [39:0]        arc_pos;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [15:0] otx;
        logic signed [15:0] oty;
        logic signed [15:0] otz;
        logic               table_empty;
        logic               dropped;
    } palt_out_t;

    // one stored polyline point
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic [39:0]        arc;
    } palt_entry_t;

    // datapath commands, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLEAR,
        OP_DROP,
        OP_EMPTY,
        OP_APPEND_FIRST,
        OP_RD_PREV,
        OP_SQX,
        OP_SQY,
        OP_SQZ,
        OP_SQEND,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_APPEND_FIN,
        OP_IDX_CLR,
        OP_RD_IDX,
        OP_NR_CMP,
        OP_IP_CK,
        OP_CLAMP,
        OP_RD_BM1,
        OP_DIVF_LOAD,
        OP_DIV_STEP,
        OP_F_SAVE,
        OP_LERP_MUL,
        OP_LERP_FIN,
        OP_LEN_SAVE,
        OP_DIVN_LOAD,
        OP_NORM_FIN,
        OP_EMIT
    } palt_op_t;

    // datapath status back to the controller
    typedef struct packed {
        palt_kind_t kind;
        logic       full;
        logic       empty;
        logic       idx_zero;
        logic       idx_last;
        logic       arc_gt;
        logic       sqrt_last;
        logic       div_last;
        logic       comp_is5;
        logic       comp_is2;
        logic       sum_zero;
    } palt_status_t;

endpackage

FILE: hw/rtl/path_arc_length_table.sv
`timescale 1ns / 1ps

// Arc-length keyed table of a 3-D polyline, up to DEPTH points. A command
// beat is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with done high, and the receiver cannot stall
// it. Busy stays high from the accepting edge until done rises. A clear, an
// append to a full or empty table and a query on an empty table go straight
// to the result beat; other appends wait on the 34-step bit-serial square
// root; a nearest query grows with the stored points, set by the table's one
// read port and the single shared multiplier; an interpolate query grows with
// the points scanned; a bracketed one adds the 64-step serial divider (up to
// four passes) and, for a nonzero tangent, the square root. The point table
// needs no clearing pass: only entries below the fill count are read.
module path_arc_length_table #(
    parameter int DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  palt_pkg::palt_in_t  cmd,
    output logic                done,
    output palt_pkg::palt_out_t result
);
    import palt_pkg::*;

    palt_op_t     op;
    palt_status_t st;

    palt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .op    (op),
        .busy  (busy)
    );

    palt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .cmd    (cmd),
        .st     (st),
        .result (result),
        .done   (done)
    );

endmodule

FILE: hw/rtl/palt_ctrl.sv
`timescale 1ns / 1ps

module palt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  palt_pkg::palt_status_t st,
    output palt_pkg::palt_op_t     op,
    output logic                  busy
);
    import palt_pkg::*;

    typedef enum logic [25:0] {
        S_IDLE     = 26'h0000001,
        S_DISP     = 26'h0000002,
        S_SQX      = 26'h0000004,
        S_SQY      = 26'h0000008,
        S_SQZ      = 26'h0000010,
        S_SQEND    = 26'h0000020,
        S_SQRT_LD  = 26'h0000040,
        S_SQRT     = 26'h0000080,
        S_APP_FIN  = 26'h0000100,
        S_NR_RD    = 26'h0000200,
        S_NR_CMP   = 26'h0000400,
        S_IP_RD    = 26'h0000800,
        S_IP_CK    = 26'h0001000,
        S_CLAMP    = 26'h0002000,
        S_RD_BM1   = 26'h0004000,
        S_DIVF_LD  = 26'h0008000,
        S_DIVF     = 26'h0010000,
        S_F_SAVE   = 26'h0020000,
        S_LERP_MUL = 26'h0040000,
        S_LERP_FIN = 26'h0080000,
        S_SUM_CHK  = 26'h0100000,
        S_LEN_SAVE = 26'h0200000,
        S_DIVN_LD  = 26'h0400000,
        S_DIVN     = 26'h0800000,
        S_NORM_FIN = 26'h1000000,
        S_EMIT     = 26'h2000000
    } palt_state_t;

    palt_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // sequencing and command decode
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (st.kind)
                    KIND_CLEAR:
                    begin
                        op         = OP_CLEAR;
                        state_next = S_EMIT;
                    end
                    KIND_APPEND:
                    begin
                        if (st.full)
                        begin
                            op         = OP_DROP;
                            state_next = S_EMIT;
                        end
                        else if (st.empty)
                        begin
                            op         = OP_APPEND_FIRST;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            op         = OP_RD_PREV;
                            state_next = S_SQX;
                        end
                    end
                    KIND_NEAREST:
                    begin
                        op         = st.empty ? OP_EMPTY : OP_IDX_CLR;
                        state_next = st.empty ? S_EMIT : S_NR_RD;
                    end
                    KIND_INTERP:
                    begin
                        op         = st.empty ? OP_EMPTY : OP_IDX_CLR;
                        state_next = st.empty ? S_EMIT : S_IP_RD;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SQX:
            begin
                op         = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                op         = OP_SQY;
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                op         = OP_SQZ;
                state_next = S_SQEND;
            end
            S_SQEND:
            begin
                op = OP_SQEND;
                if (st.kind == KIND_APPEND)
                begin
                    state_next = S_SQRT_LD;
                end
                else if (st.kind == KIND_NEAREST)
                begin
                    state_next = S_NR_CMP;
                end
                else
                begin
                    state_next = S_SUM_CHK;
                end
            end
            S_SQRT_LD:
            begin
                op         = OP_SQRT_LOAD;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op = OP_SQRT_STEP;
                if (st.sqrt_last)
                begin
                    state_next = (st.kind == KIND_APPEND) ? S_APP_FIN : S_LEN_SAVE;
                end
            end
            S_APP_FIN:
            begin
                op         = OP_APPEND_FIN;
                state_next = S_EMIT;
            end
            S_NR_RD:
            begin
                op         = OP_RD_IDX;
                state_next = S_SQX;
            end
            S_NR_CMP:
            begin
                op         = OP_NR_CMP;
                state_next = st.idx_last ? S_EMIT : S_NR_RD;
            end
            S_IP_RD:
            begin
                op         = OP_RD_IDX;
                state_next = S_IP_CK;
            end
            S_IP_CK:
            begin
                op = OP_IP_CK;
                if (st.arc_gt)
                begin
                    state_next = st.idx_zero ? S_CLAMP : S_RD_BM1;
                end
                else
                begin
                    state_next = st.idx_last ? S_CLAMP : S_IP_RD;
                end
            end
            S_CLAMP:
            begin
                op         = OP_CLAMP;
                state_next = S_EMIT;
            end
            S_RD_BM1:
            begin
                op         = OP_RD_BM1;
                state_next = S_DIVF_LD;
            end
            S_DIVF_LD:
            begin
                op         = OP_DIVF_LOAD;
                state_next = S_DIVF;
            end
            S_DIVF:
            begin
                op = OP_DIV_STEP;
                if (st.div_last)
                begin
                    state_next = S_F_SAVE;
                end
            end
            S_F_SAVE:
            begin
                op         = OP_F_SAVE;
                state_next = S_LERP_MUL;
            end
            S_LERP_MUL:
            begin
                op         = OP_LERP_MUL;
                state_next = S_LERP_FIN;
            end
            S_LERP_FIN:
            begin
                op         = OP_LERP_FIN;
                state_next = st.comp_is5 ? S_SQX : S_LERP_MUL;
            end
            S_SUM_CHK:
            begin
                state_next = st.sum_zero ? S_EMIT : S_SQRT_LD;
            end
            S_LEN_SAVE:
            begin
                op         = OP_LEN_SAVE;
                state_next = S_DIVN_LD;
            end
            S_DIVN_LD:
            begin
                op         = OP_DIVN_LOAD;
                state_next = S_DIVN;
            end
            S_DIVN:
            begin
                op = OP_DIV_STEP;
                if (st.div_last)
                begin
                    state_next = S_NORM_FIN;
                end
            end
            S_NORM_FIN:
            begin
                op         = OP_NORM_FIN;
                state_next = st.comp_is2 ? S_EMIT : S_DIVN_LD;
            end
            S_EMIT:
            begin
                op         = OP_EMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/palt_dp.sv
`timescale 1ns / 1ps

module palt_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  palt_pkg::palt_op_t      op,
    input  palt_pkg::palt_in_t      cmd,
    output palt_pkg::palt_status_t  st,
    output palt_pkg::palt_out_t     result,
    output logic                   done
);
    import palt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // point table
    palt_entry_t mem [DEPTH];
    palt_entry_t rd_reg;
    palt_entry_t p1_reg;

    palt_in_t  cmd_reg;
    palt_out_t res_reg;
    logic      done_reg;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic [5:0]    cnt_reg;
    logic [2:0]    comp_reg;

    logic [65:0] prod_reg;
    logic [65:0] acc_reg;
    logic [65:0] best_reg;

    // square root unit
    logic [67:0] rad_reg;
    logic [33:0] root_reg;
    logic [36:0] srem_reg;

    // divider unit
    logic [63:0] num_reg;
    logic [40:0] den_reg;
    logic [40:0] drem_reg;
    logic [63:0] quo_reg;

    logic [23:0]        f_reg;
    logic [31:0]        len_reg;
    logic signed [16:0] vtx_reg;
    logic signed [16:0] vty_reg;
    logic signed [16:0] vtz_reg;

    // component c of a point, sign extended
    function automatic logic signed [32:0] ent_comp(input palt_entry_t e, input logic [2:0] c);
        logic signed [32:0] v;
        case (c)
            3'd0:    v = 33'(e.x);
            3'd1:    v = 33'(e.y);
            3'd2:    v = 33'(e.z);
            3'd3:    v = 33'(e.tx);
            3'd4:    v = 33'(e.ty);
            3'd5:    v = 33'(e.tz);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] vt_sel(input logic [1:0] c,
                                                  input logic signed [16:0] a,
                                                  input logic signed [16:0] b,
                                                  input logic signed [16:0] d);
        logic signed [16:0] v;
        case (c)
            2'd0:    v = a;
            2'd1:    v = b;
            default: v = d;
        endcase
        return v;
    endfunction

    // squaring operand: coordinate offset or blended tangent
    logic [1:0]         sq_sel;
    logic signed [32:0] sq_cq;
    logic signed [33:0] sq_d;
    logic signed [16:0] sq_v;
    logic [32:0]        sq_m;

    always_comb
    begin
        case (op)
            OP_SQY:  sq_sel = 2'd1;
            OP_SQZ:  sq_sel = 2'd2;
            default: sq_sel = 2'd0;
        endcase
        case (sq_sel)
            2'd0:    sq_cq = 33'(cmd_reg.px);
            2'd1:    sq_cq = 33'(cmd_reg.py);
            default: sq_cq = 33'(cmd_reg.pz);
        endcase
        sq_d = 34'(ent_comp(rd_reg, {1'b0, sq_sel})) - 34'(sq_cq);
        sq_v = vt_sel(sq_sel, vtx_reg, vty_reg, vtz_reg);
        if (cmd_reg.kind == KIND_INTERP)
        begin
            sq_m = sq_v[16] ? 33'(-sq_v) : 33'(sq_v);
        end
        else
        begin
            sq_m = sq_d[33] ? 33'(-sq_d) : sq_d[32:0];
        end
    end

    // linear blend of component comp_reg between rd_reg and p1_reg
    logic signed [32:0] lerp_b;
    logic signed [32:0] lerp_a;
    logic signed [33:0] lerp_d;
    logic [32:0]        lerp_m;
    logic [57:0]        lerp_rnd;
    logic [33:0]        lerp_q;
    logic signed [34:0] lerp_r;

    always_comb
    begin
        lerp_b   = ent_comp(rd_reg, comp_reg);
        lerp_a   = ent_comp(p1_reg, comp_reg);
        lerp_d   = 34'(lerp_a) - 34'(lerp_b);
        lerp_m   = lerp_d[33] ? 33'(-lerp_d) : lerp_d[32:0];
        lerp_rnd = prod_reg[57:0] + 58'd8388608;
        lerp_q   = lerp_rnd[57:24];
        if (lerp_d[33])
        begin
            lerp_r = 35'(lerp_b) - 35'(lerp_q);
        end
        else
        begin
            lerp_r = 35'(lerp_b) + 35'(lerp_q);
        end
    end

    // shared multiplier
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [65:0] prod_next;

    always_comb
    begin
        if (op == OP_LERP_MUL)
        begin
            mul_a = lerp_m;
            mul_b = 33'(f_reg);
        end
        else
        begin
            mul_a = sq_m;
            mul_b = sq_m;
        end
        prod_next = mul_a * mul_b;
    end

    // one root digit per step
    logic [36:0] srem_sh;
    logic [36:0] s_trial;
    logic        s_take;

    assign srem_sh = {srem_reg[34:0], rad_reg[67:66]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_take  = (srem_sh >= s_trial);

    // one quotient bit per step
    logic [41:0] drem_sh;
    logic        d_take;
    logic [41:0] d_diff;

    assign drem_sh = {drem_reg, num_reg[63]};
    assign d_take  = (drem_sh >= {1'b0, den_reg});
    assign d_diff  = drem_sh - {1'b0, den_reg};

    // append: rounded segment length and saturated arc key
    logic [34:0] app_dist;
    logic [40:0] app_sum;
    logic [39:0] app_arc;
    logic        app_drop;

    always_comb
    begin
        app_dist = 35'(root_reg) + 35'(srem_reg > 37'(root_reg));
        app_sum  = 41'(rd_reg.arc) + 41'(app_dist);
        app_arc  = (app_sum >= 41'(ARC_MAX)) ? ARC_MAX : app_sum[39:0];
        app_drop = (app_dist == '0) || (rd_reg.arc == ARC_MAX);
    end

    // tangent normalization of component comp_reg
    logic signed [16:0] nv;
    logic [16:0]        nm;
    logic [15:0]        nres;

    always_comb
    begin
        nv = vt_sel(comp_reg[1:0], vtx_reg, vty_reg, vtz_reg);
        nm = nv[16] ? 17'(-nv) : 17'(nv);
        if (nv[16])
        begin
            nres = (quo_reg > 64'd32768) ? 16'h8000 : (~quo_reg[15:0] + 16'd1);
        end
        else
        begin
            nres = (quo_reg > 64'd32767) ? 16'h7FFF : quo_reg[15:0];
        end
    end

    // table addressing
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic          we;
    logic [AW-1:0] waddr;
    palt_entry_t   wentry;

    always_comb
    begin
        cnt_m1 = count_reg - CW'(1);
        case (op)
            OP_RD_PREV: raddr = cnt_m1[AW-1:0];
            OP_RD_BM1:  raddr = idx_reg - AW'(1);
            default:    raddr = idx_reg;
        endcase
        rd_en = (op == OP_RD_PREV) || (op == OP_RD_IDX) || (op == OP_RD_BM1);
        we    = (op == OP_APPEND_FIRST) || ((op == OP_APPEND_FIN) && !app_drop);
        waddr = (op == OP_APPEND_FIRST) ? '0 : count_reg[AW-1:0];
        wentry.x   = cmd_reg.px;
        wentry.y   = cmd_reg.py;
        wentry.z   = cmd_reg.pz;
        wentry.tx  = cmd_reg.tx;
        wentry.ty  = cmd_reg.ty;
        wentry.tz  = cmd_reg.tz;
        wentry.arc = (op == OP_APPEND_FIRST) ? '0 : app_arc;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wentry;
        end
        if (rd_en)
        begin
            rd_reg <= mem[raddr];
        end
    end

    // fill count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (op == OP_EMIT);
            if (op == OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (op == OP_APPEND_FIRST)
            begin
                count_reg <= CW'(1);
            end
            else if ((op == OP_APPEND_FIN) && !app_drop)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LATCH:
            begin
                cmd_reg <= cmd;
                res_reg <= '0;
            end
            OP_DROP:
            begin
                res_reg.dropped <= 1'b1;
            end
            OP_EMPTY:
            begin
                res_reg.table_empty <= 1'b1;
            end
            OP_SQX:
            begin
                prod_reg <= prod_next;
            end
            OP_SQY:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= prod_next;
            end
            OP_SQZ:
            begin
                acc_reg  <= acc_reg + prod_reg;
                prod_reg <= prod_next;
            end
            OP_SQEND:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            OP_SQRT_LOAD:
            begin
                rad_reg  <= (cmd_reg.kind == KIND_INTERP) ? {acc_reg[35:0], 32'd0}
                                                          : {2'b00, acc_reg};
                root_reg <= '0;
                srem_reg <= '0;
                cnt_reg  <= '0;
            end
            OP_SQRT_STEP:
            begin
                rad_reg  <= {rad_reg[65:0], 2'b00};
                srem_reg <= s_take ? (srem_sh - s_trial) : srem_sh;
                root_reg <= {root_reg[32:0], s_take};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            OP_APPEND_FIN:
            begin
                res_reg.dropped <= app_drop;
                res_reg.arc_pos <= app_drop ? '0 : app_arc;
            end
            OP_IDX_CLR:
            begin
                idx_reg <= '0;
            end
            OP_NR_CMP:
            begin
                if ((idx_reg == '0) || (acc_reg < best_reg))
                begin
                    best_reg        <= acc_reg;
                    res_reg.arc_pos <= rd_reg.arc;
                end
                if (!st.idx_last)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            OP_IP_CK:
            begin
                p1_reg <= rd_reg;
                if (!st.arc_gt && !st.idx_last)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            OP_CLAMP:
            begin
                res_reg.ox  <= rd_reg.x;
                res_reg.oy  <= rd_reg.y;
                res_reg.oz  <= rd_reg.z;
                res_reg.otx <= rd_reg.tx;
                res_reg.oty <= rd_reg.ty;
                res_reg.otz <= rd_reg.tz;
            end
            OP_DIVF_LOAD:
            begin
                num_reg  <= {cmd_reg.arc_query - rd_reg.arc, 24'd0};
                den_reg  <= 41'(p1_reg.arc) - 41'(rd_reg.arc);
                drem_reg <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            OP_DIV_STEP:
            begin
                num_reg  <= {num_reg[62:0], 1'b0};
                drem_reg <= d_take ? d_diff[40:0] : drem_sh[40:0];
                quo_reg  <= {quo_reg[62:0], d_take};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            OP_F_SAVE:
            begin
                f_reg    <= quo_reg[23:0];
                comp_reg <= '0;
            end
            OP_LERP_MUL:
            begin
                prod_reg <= prod_next;
            end
            OP_LERP_FIN:
            begin
                case (comp_reg)
                    3'd0:    res_reg.ox <= lerp_r[31:0];
                    3'd1:    res_reg.oy <= lerp_r[31:0];
                    3'd2:    res_reg.oz <= lerp_r[31:0];
                    3'd3:    vtx_reg    <= lerp_r[16:0];
                    3'd4:    vty_reg    <= lerp_r[16:0];
                    default: vtz_reg    <= lerp_r[16:0];
                endcase
                comp_reg <= comp_reg + 3'd1;
            end
            OP_LEN_SAVE:
            begin
                len_reg  <= root_reg[31:0];
                comp_reg <= '0;
            end
            OP_DIVN_LOAD:
            begin
                num_reg  <= {16'd0, nm, 31'd0} + 64'(len_reg[31:1]);
                den_reg  <= 41'(len_reg);
                drem_reg <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            OP_NORM_FIN:
            begin
                case (comp_reg[1:0])
                    2'd0:    res_reg.otx <= nres;
                    2'd1:    res_reg.oty <= nres;
                    default: res_reg.otz <= nres;
                endcase
                comp_reg <= comp_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // status to the controller
    always_comb
    begin
        st.kind      = cmd_reg.kind;
        st.full      = (count_reg >= CW'(DEPTH));
        st.empty     = (count_reg == '0);
        st.idx_zero  = (idx_reg == '0);
        st.idx_last  = (CW'(idx_reg) == cnt_m1);
        st.arc_gt    = (rd_reg.arc > cmd_reg.arc_query);
        st.sqrt_last = (cnt_reg == 6'(SQRT_STEPS - 1));
        st.div_last  = (cnt_reg == 6'(DIV_STEPS - 1));
        st.comp_is5  = (comp_reg == 3'd5);
        st.comp_is2  = (comp_reg == 3'd2);
        st.sum_zero  = (acc_reg == '0);
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import palt_pkg::*;

    localparam int DEPTH = 1024;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    palt_in_t  cmd;
    logic      done;
    palt_out_t result;

    path_arc_length_table #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // shadow copy of the point table
    int              pt_x [DEPTH];
    int              pt_y [DEPTH];
    int              pt_z [DEPTH];
    shortint         pt_tx [DEPTH];
    shortint         pt_ty [DEPTH];
    shortint         pt_tz [DEPTH];
    longint unsigned pt_arc [DEPTH];
    int              fill_count;

    palt_out_t expected_beats[$];
    int        errors;
    int        beats_checked;
    int        burst_left;
    bit        no_idle;
    int        kind_seen [4];
    int        drops_seen;

    // last appended point, used to build short random segments
    int last_x, last_y, last_z;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // floor square root of a 128-bit value
    function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        r = '0;
        b = 128'd1 << 126;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs_diff(input longint a, input longint b);
        longint d;
        d = a - b;
        return (d < 0) ? longint'(-d) : d;
    endfunction

    function automatic logic [127:0] dist_sq(input int i, input longint x,
                                             input longint y, input longint z);
        logic [127:0] dx, dy, dz;
        dx = abs_diff(pt_x[i], x);
        dy = abs_diff(pt_y[i], y);
        dz = abs_diff(pt_z[i], z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // v0 + round((v1 - v0) * f / 2^24), ties away from zero
    function automatic longint blend(input longint v0, input longint v1,
                                     input longint unsigned f);
        longint          d;
        longint unsigned m, q;
        d = v1 - v0;
        m = (d < 0) ? longint'(-d) : d;
        q = (m * f + (64'd1 << 23)) >> 24;
        return (d < 0) ? v0 - longint'(q) : v0 + longint'(q);
    endfunction

    function automatic shortint unit_comp(input longint v, input longint unsigned len);
        longint unsigned m, q;
        m = (v < 0) ? longint'(-v) : v;
        q = ((m << 31) + len / 2) / len;
        if (v < 0)
            return (q > 32768) ? -16'sd32768 : shortint'(-longint'(q));
        return (q > 32767) ? 16'sd32767 : shortint'(q);
    endfunction

    // advance the shadow table by one command and return the expected beat
    function automatic palt_out_t table_step(input palt_in_t c);
        palt_out_t       o;
        logic [127:0]    s, r;
        longint unsigned d, prev, t, span, f, ssum, len;
        longint          v [3];
        int              i, b, k;
        o = '0;
        t = 64'(c.arc_query);
        case (c.kind)
            KIND_CLEAR: fill_count = 0;
            KIND_APPEND:
            begin
                if (fill_count >= DEPTH)
                    o.dropped = 1'b1;
                else
                begin
                    d = 0;
                    if (fill_count > 0)
                    begin
                        prev = pt_arc[fill_count - 1];
                        s = dist_sq(fill_count - 1, c.px, c.py, c.pz);
                        r = floor_sqrt(s);
                        if (s > r * r + r)
                            r = r + 1;
                        d = r[63:0];
                        if (d == 0 || prev >= ARC_MAX)
                            o.dropped = 1'b1;
                        else
                            d = (d >= ARC_MAX - prev) ? ARC_MAX : prev + d;
                    end
                    if (!o.dropped)
                    begin
                        pt_x[fill_count]   = c.px;
                        pt_y[fill_count]   = c.py;
                        pt_z[fill_count]   = c.pz;
                        pt_tx[fill_count]  = c.tx;
                        pt_ty[fill_count]  = c.ty;
                        pt_tz[fill_count]  = c.tz;
                        pt_arc[fill_count] = d;
                        fill_count++;
                        o.arc_pos = d[39:0];
                    end
                end
            end
            default:
            begin
                if (fill_count == 0)
                    o.table_empty = 1'b1;
                else if (c.kind == KIND_NEAREST)
                begin
                    // first point with the strictly least distance wins
                    s = dist_sq(0, c.px, c.py, c.pz);
                    o.arc_pos = pt_arc[0][39:0];
                    for (i = 1; i < fill_count; i++)
                    begin
                        r = dist_sq(i, c.px, c.py, c.pz);
                        if (r < s)
                        begin
                            s = r;
                            o.arc_pos = pt_arc[i][39:0];
                        end
                    end
                end
                else
                begin
                    i = 0;
                    while (i < fill_count && pt_arc[i] <= t)
                        i++;
                    if (i == fill_count || i == 0)
                    begin
                        // clamp to an end point
                        k = (i == fill_count) ? fill_count - 1 : 0;
                        o.ox  = pt_x[k];
                        o.oy  = pt_y[k];
                        o.oz  = pt_z[k];
                        o.otx = pt_tx[k];
                        o.oty = pt_ty[k];
                        o.otz = pt_tz[k];
                    end
                    else
                    begin
                        b = i - 1;
                        span = pt_arc[i] - pt_arc[b];
                        f = ((t - pt_arc[b]) << 24) / span;
                        o.ox = 32'(blend(pt_x[b], pt_x[i], f));
                        o.oy = 32'(blend(pt_y[b], pt_y[i], f));
                        o.oz = 32'(blend(pt_z[b], pt_z[i], f));
                        v[0] = blend(pt_tx[b], pt_tx[i], f);
                        v[1] = blend(pt_ty[b], pt_ty[i], f);
                        v[2] = blend(pt_tz[b], pt_tz[i], f);
                        ssum = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
                        // degenerate tangent leaves zeros
                        if (ssum != 0)
                        begin
                            r = floor_sqrt({64'd0, ssum << 32});
                            len = r[63:0];
                            o.otx = unit_comp(v[0], len);
                            o.oty = unit_comp(v[1], len);
                            o.otz = unit_comp(v[2], len);
                        end
                    end
                end
            end
        endcase
        return o;
    endfunction

    // send one command beat; returns at the falling edge after acceptance
    task automatic send_beat(input palt_in_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_beats.push_back(table_step(c));
        kind_seen[c.kind]++;
        if (c.kind == KIND_APPEND)
        begin
            last_x = c.px;
            last_y = c.py;
            last_z = c.pz;
        end
        @(negedge clk);
        // sender bursts and gaps
        if (!no_idle)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 25))
                    @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    function automatic palt_in_t make_cmd(input palt_kind_t k, input int x, input int y,
                                          input int z, input shortint tx, input shortint ty,
                                          input shortint tz, input logic [39:0] q);
        palt_in_t c;
        c.kind = k;
        c.px = x;
        c.py = y;
        c.pz = z;
        c.tx = tx;
        c.ty = ty;
        c.tz = tz;
        c.arc_query = q;
        return c;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        palt_out_t e;
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, result);
                errors++;
            end
            else
            begin
                e = expected_beats.pop_front();
                beats_checked++;
                check_field("arc_pos", e.arc_pos, result.arc_pos);
                check_field("ox", e.ox, result.ox);
                check_field("oy", e.oy, result.oy);
                check_field("oz", e.oz, result.oz);
                check_field("otx", e.otx, result.otx);
                check_field("oty", e.oty, result.oty);
                check_field("otz", e.otz, result.otz);
                check_field("table_empty", e.table_empty, result.table_empty);
                check_field("dropped", e.dropped, result.dropped);
                if (e.dropped)
                    drops_seen++;
            end
        end
    end

    // empty table, rounding, clamping, blending and field extremes
    task automatic test_directed();
        send_beat(make_cmd(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, 40'd5));
        send_beat(make_cmd(KIND_CLEAR, -1, -1, -1, -1, -1, -1, '1));
        send_beat(make_cmd(KIND_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 0,
                           -16'sd32768, 16'sd32767, 0, 0));
        // zero-length segment
        send_beat(make_cmd(KIND_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 0, 1, 1, 1, 0));
        send_beat(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_APPEND, 0, 0, 0, 16'sd32767, 0, 0, 0));
        // repeated point is a zero-length segment
        send_beat(make_cmd(KIND_APPEND, 0, 0, 0, 0, 0, 0, 0));
        // one-unit steps: along one axis, then across two (sqrt 2 rounds down)
        send_beat(make_cmd(KIND_APPEND, 1, 0, 0, 0, 16'sd32767, 0, 0));
        send_beat(make_cmd(KIND_APPEND, 1, 1, 1, 0, 0, 16'sd32767, 0));
        // opposite tangent for a degenerate blend
        send_beat(make_cmd(KIND_APPEND, 32'sd655360, 0, 0, 0, 0, -16'sd32767, 0));
        send_beat(make_cmd(KIND_APPEND, 32'sd655360, 32'sd655360, -32'sd655360,
                           -16'sd32768, -16'sd32768, -16'sd32768, 0));
        send_beat(make_cmd(KIND_NEAREST, 1, 1, 1, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_NEAREST, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           0, 0, 0, 0));
        send_beat(make_cmd(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, 40'd0));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, 40'd1));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0,
                           40'(pt_arc[3] + (pt_arc[4] - pt_arc[3]) / 2)));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, 40'(pt_arc[4] - 1)));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, 40'(pt_arc[fill_count - 1])));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, '1));
    endtask

    // long jumps until the arc saturates, then a further append is dropped
    task automatic test_arc_saturation();
        int n;
        no_idle = 1'b1;
        send_beat(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        n = 0;
        while (fill_count == 0 || pt_arc[fill_count - 1] != ARC_MAX)
        begin
            if (n[0])
                send_beat(make_cmd(KIND_APPEND, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                   32'sh7fff_ffff, 16'sd100, 0, 0, 0));
            else
                send_beat(make_cmd(KIND_APPEND, 32'sh8000_0000, 32'sh8000_0000,
                                   32'sh8000_0000, 0, -16'sd100, 0, 0));
            n++;
        end
        no_idle = 1'b0;
        send_beat(make_cmd(KIND_APPEND, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, ARC_MAX - 40'd1));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, ARC_MAX));
        send_beat(make_cmd(KIND_NEAREST, 5, 5, 5, 0, 0, 0, 0));
    endtask

    // fill every entry, then overflow the table
    task automatic test_table_full();
        int i;
        no_idle = 1'b1;
        send_beat(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        for (i = 0; i < DEPTH; i++)
            send_beat(make_cmd(KIND_APPEND, i * 65536, -i * 3000, i, shortint'(i * 37),
                               16'sd1000, -16'sd5, 0));
        no_idle = 1'b0;
        send_beat(make_cmd(KIND_APPEND, 32'sh4000_0000, 0, 0, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_NEAREST, 1023 * 65536, -1023 * 3000, 1023, 0, 0, 0, 0));
        send_beat(make_cmd(KIND_INTERP, 0, 0, 0, 0, 0, 0, 40'(pt_arc[700] + 12345)));
    endtask

    // mostly short well-formed polylines with queries, some noise
    task automatic test_random(input int count);
        palt_in_t c;
        int       sel, i;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            c.tx = 16'($urandom);
            c.ty = 16'($urandom);
            c.tz = 16'($urandom);
            c.px = $urandom;
            c.py = $urandom;
            c.pz = $urandom;
            c.arc_query = 40'({$urandom, $urandom});
            if (sel < 3)
                c.kind = KIND_CLEAR;
            else if (sel < 50)
            begin
                c.kind = KIND_APPEND;
                // short step from the last point, a repeat, or a wild jump
                if (sel < 42)
                begin
                    c.px = last_x + $urandom_range(0, 1 << 21) - (1 << 20);
                    c.py = last_y + $urandom_range(0, 1 << 21) - (1 << 20);
                    c.pz = last_z + $urandom_range(0, 1 << 10) - (1 << 9);
                end
                else if (sel < 45)
                begin
                    c.px = last_x;
                    c.py = last_y;
                    c.pz = last_z;
                end
            end
            else if (sel < 75)
            begin
                c.kind = KIND_NEAREST;
                if (sel < 68)
                begin
                    c.px = last_x + $urandom_range(0, 1 << 22) - (1 << 21);
                    c.py = last_y + $urandom_range(0, 1 << 22) - (1 << 21);
                    c.pz = last_z;
                end
            end
            else
            begin
                c.kind = KIND_INTERP;
                if (sel < 95 && fill_count > 0)
                    c.arc_query = 40'({$urandom, $urandom} % (pt_arc[fill_count - 1] + 2));
            end
            // sometimes run back to back
            if (i % 100 == 0)
                no_idle = ~no_idle;
            send_beat(c);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        beats_checked = 0;
        fill_count = 0;
        burst_left = 0;
        no_idle = 1'b0;
        drops_seen = 0;
        last_x = 0;
        last_y = 0;
        last_z = 0;
        kind_seen = '{0, 0, 0, 0};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_arc_saturation();
        test_table_full();
        send_beat(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        test_random(580);

        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        $display("tb: %0d result beats checked, %0d appends dropped", beats_checked,
                 drops_seen);
        $display("tb: clears %0d, appends %0d, nearest %0d, interpolate %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (errors == 0 && expected_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit, well above a full-table nearest query on every beat
    initial
    begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
